/* rtl/core/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg
// shared types and constants for the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

    // sequencer phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LOW    = 3'd1;
    localparam logic [2:0] PH_HIGH   = 3'd2;
    localparam logic [2:0] PH_SETTLE = 3'd3;
    localparam logic [2:0] PH_RISE   = 3'd4;
    localparam logic [2:0] PH_ECHO   = 3'd5;

    // measurement status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_ECHO  = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_TOO_NEAR = 3'd3;
    localparam logic [2:0] ST_TOO_FAR  = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 3'd5;

    // configuration reset values
    localparam logic [9:0]  RST_MAX_CM   = 10'd400;
    localparam logic [9:0]  RST_MIN_CM   = 10'd2;
    localparam logic [15:0] RST_TIMEOUT  = 16'd25000;
    localparam logic [7:0]  RST_TRIG     = 8'd10;
    localparam logic [7:0]  RST_IDLE_LOW = 8'd2;
    localparam logic [15:0] RST_SETTLE   = 16'd1000;

    // echo time per centimetre of range, in microseconds
    localparam int US_PER_CM = 58;

    // field widths
    localparam int DIST_W   = 14;
    localparam int STATUS_W = 3;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 24;
    localparam logic [DIST_W-1:0] DIST_MAX = 14'h3FFF;

    typedef struct packed {
        logic [9:0]  max_cm;
        logic [9:0]  min_cm;
        logic [15:0] timeout_us;
        logic [7:0]  trig_us;
        logic [7:0]  idle_low_us;
        logic [15:0] settle_us;
    } cfg_t;

    // per-transfer flags from the sequencer
    typedef struct packed {
        logic       trigger;
        logic       busy;
        logic       done;
        logic [2:0] code;
    } seq_flags_t;

endpackage

/* rtl/core/uer_seq.sv */
// ----------------------------------------------------------------------------
// uer_seq
// trigger / echo phase sequencer with saturating tick counter
// ----------------------------------------------------------------------------
module uer_seq #(
    parameter int COUNT_BITS = 17
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   start_req,
    input  logic                   tick,
    input  logic                   echo_level,
    input  uer_pkg::cfg_t          cfg,
    output uer_pkg::seq_flags_t    flags,
    output logic [COUNT_BITS-1:0]  pulse
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic [COUNT_BITS-1:0] cnt_bumped;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      limit_ext;
    logic                  cnt_sat;
    logic                  timed_out;
    logic                  done;
    logic [2:0]            code;

    assign cnt_ext    = CMP_W'(cnt_reg);
    assign cnt_sat    = &cnt_reg;
    assign cnt_bumped = (tick && !cnt_sat) ? cnt_reg + COUNT_BITS'(1) : cnt_reg;
    assign timed_out  = (cnt_ext > CMP_W'(cfg.timeout_us)) || cnt_sat;

    always_comb
    begin
        case (phase_reg)
            uer_pkg::PH_LOW:    limit_ext = CMP_W'(cfg.idle_low_us);
            uer_pkg::PH_HIGH:   limit_ext = CMP_W'(cfg.trig_us);
            uer_pkg::PH_SETTLE: limit_ext = CMP_W'(cfg.settle_us);
            default:            limit_ext = '0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        code       = uer_pkg::ST_OK;
        case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    phase_next = uer_pkg::PH_LOW;
                    cnt_next   = '0;
                end
            end
            uer_pkg::PH_LOW, uer_pkg::PH_HIGH, uer_pkg::PH_SETTLE:
            begin
                if (cnt_ext >= limit_ext)
                begin
                    phase_next = phase_reg + 3'd1;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_bumped;
                end
            end
            uer_pkg::PH_RISE:
            begin
                if (echo_level)
                begin
                    phase_next = uer_pkg::PH_ECHO;
                    cnt_next   = '0;
                end
                else if (timed_out)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                    cnt_next   = '0;
                    done       = 1'b1;
                    code       = uer_pkg::ST_NO_ECHO;
                end
                else
                begin
                    cnt_next = cnt_bumped;
                end
            end
            uer_pkg::PH_ECHO:
            begin
                if (!echo_level)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                    cnt_next   = '0;
                    done       = 1'b1;
                end
                else if (timed_out)
                begin
                    phase_next = uer_pkg::PH_IDLE;
                    cnt_next   = '0;
                    done       = 1'b1;
                    code       = uer_pkg::ST_TOO_LONG;
                end
                else
                begin
                    cnt_next = cnt_bumped;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uer_pkg::PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign flags.trigger = (phase_next == uer_pkg::PH_HIGH);
    assign flags.busy    = (phase_next != uer_pkg::PH_IDLE);
    assign flags.done    = done;
    assign flags.code    = code;
    // echo high time, only used when the echo fell
    assign pulse         = cnt_reg;

endmodule

/* rtl/core/ultrasonic_echo_ranger.sv */
// throughput: one transfer per cycle while the output is not stalled;
// sequencer, divider multiply and result format each own one pipeline
// stage, a stalled output lets stages fill up
// reset: rst_n asynchronous, active low; sequencer idle, held distance and
// status zero, configuration back to its defaults, output empty
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// ranging sequencer: trigger pulse, echo wait and echo timing, with the
// echo time converted to distance in 1/16 cm and range checked
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = 17,  // tick counter width
    parameter int FRAC_BITS  = 4    // fraction bits of the distance
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] start_req, [1] tick, [2] echo_level, [7:3] zero
    input  logic [uer_pkg::IN_W-1:0]          s_axis_tdata,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] trigger, [1] busy_res, [2] done_res, [16:3] distance_q4,
    // [19:17] status, [23:20] zero
    output logic [uer_pkg::OUT_W-1:0]         m_axis_tdata
);

    // the divide by 58 is done as a multiply by a rounded-up reciprocal;
    // only pulses up to 58 * 1023 can give an ok result, so 16 bits suffice
    localparam int CMP_W    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int NUM_W    = 16 + FRAC_BITS;
    localparam int SHIFT    = NUM_W + 6;
    localparam int M_W      = NUM_W + 1;
    localparam int PROD_W   = NUM_W + M_W;
    localparam int Q_W      = PROD_W - SHIFT;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(uer_pkg::US_PER_CM) - 64'd1) / 64'(uer_pkg::US_PER_CM);
    localparam logic [M_W-1:0] RECIP_M = RECIP_FULL[M_W-1:0];

    // configuration registers
    uer_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_cm      <= uer_pkg::RST_MAX_CM;
            cfg_reg.min_cm      <= uer_pkg::RST_MIN_CM;
            cfg_reg.timeout_us  <= uer_pkg::RST_TIMEOUT;
            cfg_reg.trig_us     <= uer_pkg::RST_TRIG;
            cfg_reg.idle_low_us <= uer_pkg::RST_IDLE_LOW;
            cfg_reg.settle_us   <= uer_pkg::RST_SETTLE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uer_pkg::REG_MAX_CM:   cfg_reg.max_cm      <= cfg_data[9:0];
                uer_pkg::REG_MIN_CM:   cfg_reg.min_cm      <= cfg_data[9:0];
                uer_pkg::REG_TIMEOUT:  cfg_reg.timeout_us  <= cfg_data;
                uer_pkg::REG_TRIG:     cfg_reg.trig_us     <= cfg_data[7:0];
                uer_pkg::REG_IDLE_LOW: cfg_reg.idle_low_us <= cfg_data[7:0];
                uer_pkg::REG_SETTLE:   cfg_reg.settle_us   <= cfg_data;
                default:               ;  // unknown index, write dropped
            endcase
        end
    end

    // pipeline handshake: each stage takes a transfer when it is empty or
    // its content moves on in the same cycle
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_xfer;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_xfer       = s_axis_tvalid && s1_ready;

    // stage 1: sequencer step for the accepted transfer
    uer_pkg::seq_flags_t   seq_flags;
    logic [COUNT_BITS-1:0] seq_pulse;

    uer_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_xfer),
        .start_req  (s_axis_tdata[0]),
        .tick       (s_axis_tdata[1]),
        .echo_level (s_axis_tdata[2]),
        .cfg        (cfg_reg),
        .flags      (seq_flags),
        .pulse      (seq_pulse)
    );

    uer_pkg::seq_flags_t   s1_flags_reg;
    logic [COUNT_BITS-1:0] s1_pulse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_flags_reg <= seq_flags;
            s1_pulse_reg <= seq_pulse;
        end
    end

    // stage 2: reciprocal multiply and range compares
    logic [CMP_W-1:0]  pulse_ext;
    logic [NUM_W-1:0]  num;
    logic [15:0]       min_us;
    logic [15:0]       max_us;
    logic [PROD_W-1:0] prod_next;
    logic              near_next;
    logic              far_next;

    assign pulse_ext = CMP_W'(s1_pulse_reg);
    assign num       = NUM_W'(pulse_ext[15:0]) << FRAC_BITS;
    assign min_us    = 16'(cfg_reg.min_cm) * 16'(uer_pkg::US_PER_CM);
    assign max_us    = 16'(cfg_reg.max_cm) * 16'(uer_pkg::US_PER_CM);
    assign prod_next = PROD_W'(num) * PROD_W'(RECIP_M);
    assign near_next = pulse_ext < CMP_W'(min_us);
    assign far_next  = pulse_ext > CMP_W'(max_us);

    uer_pkg::seq_flags_t s2_flags_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic                s2_near_reg;
    logic                s2_far_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_flags_reg <= s1_flags_reg;
            s2_prod_reg  <= prod_next;
            s2_near_reg  <= near_next;
            s2_far_reg   <= far_next;
        end
    end

    // stage 3: status, failure value, saturation and the held result
    logic [Q_W-1:0]                 quot;
    logic [NUM_W-1:0]               dist_wide;
    logic [2:0]                     status_new;
    logic [uer_pkg::DIST_W-1:0]     dist_new;
    logic [uer_pkg::DIST_W-1:0]     dist_hold_reg;
    logic [uer_pkg::DIST_W-1:0]     dist_hold_next;
    logic [uer_pkg::STATUS_W-1:0]   status_hold_reg;
    logic [uer_pkg::STATUS_W-1:0]   status_hold_next;

    assign quot = s2_prod_reg[PROD_W-1:SHIFT];

    always_comb
    begin
        status_new = s2_flags_reg.code;
        if (s2_flags_reg.code == uer_pkg::ST_OK)
        begin
            if (s2_near_reg)
            begin
                status_new = uer_pkg::ST_TOO_NEAR;
            end
            else if (s2_far_reg)
            begin
                status_new = uer_pkg::ST_TOO_FAR;
            end
        end
        // any failure reports max_cm
        if (status_new == uer_pkg::ST_OK)
        begin
            dist_wide = NUM_W'(quot);
        end
        else
        begin
            dist_wide = NUM_W'(cfg_reg.max_cm) << FRAC_BITS;
        end
        if (dist_wide > NUM_W'(uer_pkg::DIST_MAX))
        begin
            dist_new = uer_pkg::DIST_MAX;
        end
        else
        begin
            dist_new = dist_wide[uer_pkg::DIST_W-1:0];
        end
        if (s2_flags_reg.done)
        begin
            dist_hold_next   = dist_new;
            status_hold_next = status_new;
        end
        else
        begin
            dist_hold_next   = dist_hold_reg;
            status_hold_next = status_hold_reg;
        end
    end

    logic [uer_pkg::OUT_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            dist_hold_reg   <= '0;
            status_hold_reg <= '0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                dist_hold_reg   <= dist_hold_next;
                status_hold_reg <= status_hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_data_reg <= {4'b0000, status_hold_next, dist_hold_next,
                             s2_flags_reg.done, s2_flags_reg.busy,
                             s2_flags_reg.trigger};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/core/uer_checker.sv */
// ----------------------------------------------------------------------------
// uer_checker
// port-level checks on the ranger result stream
// ----------------------------------------------------------------------------
module uer_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [uer_pkg::OUT_W-1:0] m_axis_tdata
);

    // no result is offered in the cycle after reset is seen
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result offered during reset");

    // the trigger is only driven inside a measurement
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
        else $error("trigger high while not busy");

    // the finishing transfer shows the sequencer back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (!m_axis_tdata[1] && !m_axis_tdata[0]))
        else $error("done while still busy");

    // status is one of the defined codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[19:17] <= uer_pkg::ST_TOO_FAR))
        else $error("undefined status code");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ultrasonic echo ranger: drives sample streams
// shaped by a cycle-true predictor of the sequencer and checks every result
// field by field against the predicted reading, under several timing settings
// ----------------------------------------------------------------------------
module tb_top;

    import uer_pkg::*;

    localparam int          COUNT_BITS    = 17;
    localparam int          FRAC_BITS     = 4;
    localparam int unsigned CNT_MAX       = (1 << COUNT_BITS) - 1;
    localparam int          LATENCY       = 3;
    localparam int          STALL_LIMIT   = 1000;   // cycles with no transfer at all
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          RUNS_PER_MODE = 3;

    // indexes beyond the register file, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // one result transfer as the sequencer should report it
    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] distance;
        logic [2:0]        code;
    } reading_t;

    // ------------------------------------------------------------------------
    // ranging predictor and store of expected readings
    // ------------------------------------------------------------------------
    class echo_range_tracker;
        logic [9:0]        max_cm;
        logic [9:0]        min_cm;
        logic [15:0]       timeout_us;
        logic [7:0]        trig_us;
        logic [7:0]        idle_low_us;
        logic [15:0]       settle_us;
        logic [2:0]        phase;
        int unsigned       ticks;
        logic [DIST_W-1:0] dist_hold;
        logic [2:0]        status_hold;
        reading_t          pending_readings[$];
        int unsigned       mismatches;

        function new();
            max_cm      = RST_MAX_CM;
            min_cm      = RST_MIN_CM;
            timeout_us  = RST_TIMEOUT;
            trig_us     = RST_TRIG;
            idle_low_us = RST_IDLE_LOW;
            settle_us   = RST_SETTLE;
            phase       = PH_IDLE;
            ticks       = 0;
            dist_hold   = '0;
            status_hold = ST_OK;
            mismatches  = 0;
        endfunction

        function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_MAX_CM:   max_cm      = value[9:0];
                REG_MIN_CM:   min_cm      = value[9:0];
                REG_TIMEOUT:  timeout_us  = value[15:0];
                REG_TRIG:     trig_us     = value[7:0];
                REG_IDLE_LOW: idle_low_us = value[7:0];
                REG_SETTLE:   settle_us   = value[15:0];
                default:      ;
            endcase
        endfunction

        function void bump(bit tick);
            if (tick && ticks < CNT_MAX)
                ticks++;
        endfunction

        // timed phase: move on once the count has reached the phase length
        function void advance(int unsigned limit, logic [2:0] next_phase, bit tick);
            if (ticks >= limit)
            begin
                phase = next_phase;
                ticks = 0;
            end
            else
                bump(tick);
        endfunction

        function bit expired();
            return (ticks > timeout_us) || (ticks == CNT_MAX);
        endfunction

        function void conclude(logic [2:0] code, int unsigned pulse);
            longint unsigned q;
            logic [2:0]      c;
            c = code;
            if (c == ST_OK)
            begin
                if (pulse < US_PER_CM * min_cm)
                    c = ST_TOO_NEAR;
                else if (pulse > US_PER_CM * max_cm)
                    c = ST_TOO_FAR;
            end
            if (c == ST_OK)
            begin
                q = 64'(pulse);
                q = (q << FRAC_BITS) / US_PER_CM;
            end
            else
            begin
                q = 64'(max_cm);
                q = q << FRAC_BITS;
            end
            dist_hold   = (q > DIST_MAX) ? DIST_MAX : q[DIST_W-1:0];
            status_hold = c;
            phase       = PH_IDLE;
            ticks       = 0;
        endfunction

        // one accepted sample: step the sequencer and queue its reading
        function void take_sample(bit start, bit tick, bit echo);
            reading_t r;
            bit       done;
            done = 1'b0;
            case (phase)
                PH_IDLE:
                    if (start)
                    begin
                        phase = PH_LOW;
                        ticks = 0;
                    end
                PH_LOW:    advance(32'(idle_low_us), PH_HIGH, tick);
                PH_HIGH:   advance(32'(trig_us), PH_SETTLE, tick);
                PH_SETTLE: advance(32'(settle_us), PH_RISE, tick);
                PH_RISE:
                    if (echo)
                    begin
                        phase = PH_ECHO;
                        ticks = 0;
                    end
                    else if (expired())
                    begin
                        conclude(ST_NO_ECHO, 0);
                        done = 1'b1;
                    end
                    else
                        bump(tick);
                PH_ECHO:
                    if (!echo)
                    begin
                        conclude(ST_OK, ticks);
                        done = 1'b1;
                    end
                    else if (expired())
                    begin
                        conclude(ST_TOO_LONG, 0);
                        done = 1'b1;
                    end
                    else
                        bump(tick);
                default:
                begin
                    phase = PH_IDLE;
                    ticks = 0;
                end
            endcase
            r.trigger  = (phase == PH_HIGH);
            r.busy     = (phase != PH_IDLE);
            r.done     = done;
            r.distance = dist_hold;
            r.code     = status_hold;
            pending_readings.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_reading(logic [OUT_W-1:0] data);
            reading_t want;
            if (pending_readings.size() == 0)
            begin
                $error("result transfer with nothing expected, tdata %h", data);
                mismatches++;
                return;
            end
            want = pending_readings.pop_front();
            compare_field("trigger",     16'(want.trigger),  16'(data[0]));
            compare_field("busy_res",    16'(want.busy),     16'(data[1]));
            compare_field("done_res",    16'(want.done),     16'(data[2]));
            compare_field("distance_q4", 16'(want.distance), 16'(data[16:3]));
            compare_field("status",      16'(want.code),     16'(data[19:17]));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;

    echo_range_tracker tracker;

    // idling odds per cycle, in percent, for each side
    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 48;

    int unsigned samples_sent = 0;
    int unsigned runs_done    = 0;
    int unsigned idle_cycles  = 0;

    // current range and timeout, used to shape the random runs
    int unsigned cur_max     = RST_MAX_CM;
    int unsigned cur_timeout = RST_TIMEOUT;

    ultrasonic_echo_ranger #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check each transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_reading(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: a long stretch with no transfer on any port means a hang
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // one sample transfer, with random sender gaps ahead of it
    task automatic send_sample(bit start, bit tick, bit echo);
        logic [IN_W-1:0] word;
        word    = '0;
        word[0] = start;
        word[1] = tick;
        word[2] = echo;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_sample(start, tick, echo);
        samples_sent++;
    endtask

    // one measurement: echo rises once rise_wait ticks have passed in the
    // rise wait and falls after pulse ticks; the predicted count steers it
    task automatic measure(int unsigned rise_wait, int unsigned pulse, int unsigned tick_pct);
        bit start;
        bit tick;
        bit echo;
        start = 1'b1;
        do
        begin
            tick = ($urandom_range(99) < tick_pct);
            case (tracker.phase)
                PH_RISE: echo = (tracker.ticks >= rise_wait);
                PH_ECHO: echo = (tracker.ticks < pulse);
                default: echo = 1'($urandom_range(1));   // echo is ignored here
            endcase
            send_sample(start, tick, echo);
            start = 1'($urandom_range(1));               // stray starts while busy
        end
        while (tracker.phase != PH_IDLE);
        runs_done++;
    endtask

    // let every expected reading arrive, then allow the pipeline to settle
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_readings.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY + 2) @(posedge clk);
    endtask

    // write all six registers plus both spare indexes, junk in unused bits
    task automatic configure(int unsigned mx, int unsigned mn, int unsigned tmo,
                             int unsigned trg, int unsigned idl, int unsigned stl);
        logic [CFG_IDX_W-1:0]  reg_index [8];
        logic [CFG_DATA_W-1:0] reg_value [8];
        logic [CFG_DATA_W-1:0] reg_mask  [8];
        logic [CFG_DATA_W-1:0] word;
        reg_index = '{REG_MAX_CM, REG_MIN_CM, REG_TIMEOUT, REG_TRIG,
                      REG_IDLE_LOW, REG_SETTLE, REG_SPARE_LO, REG_SPARE_HI};
        reg_value = '{16'(mx), 16'(mn), 16'(tmo), 16'(trg), 16'(idl), 16'(stl),
                      16'h0000, 16'h0000};
        reg_mask  = '{16'h03FF, 16'h03FF, 16'hFFFF, 16'h00FF, 16'h00FF, 16'hFFFF,
                      16'h0000, 16'h0000};
        for (int i = 0; i < 8; i++)
        begin
            word      = reg_value[i] | (16'($urandom) & ~reg_mask[i]);
            cfg_we    <= 1'b1;
            cfg_index <= reg_index[i];
            cfg_data  <= word;
            @(posedge clk);
            tracker.write_setting(reg_index[i], word);
        end
        cfg_we      <= 1'b0;
        cur_max     = mx;
        cur_timeout = tmo;
    endtask

    initial
    begin
        int unsigned random_base;
        int unsigned mode_runs;
        int unsigned mx;
        int unsigned mn;
        int unsigned tmo;
        int unsigned trg;
        int unsigned kind;
        int unsigned rise;
        int unsigned pulse;

        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle samples with no start, then a start under the reset settings
        // and a burst of every input combination while busy
        for (int k = 0; k < 4; k++)
            send_sample(1'b0, k[0], k[1]);
        send_sample(1'b1, 1'b1, 1'b1);
        for (int k = 0; k < 8; k++)
            send_sample(k[0], k[1], k[2]);
        quiesce();

        // shortest phases and a one-tick timeout; the run left in flight
        // finishes under these settings
        configure(2, 0, 1, 1, 0, 0);
        measure(0, 0, 100);        // zero pulse, accepted as min is zero
        measure(0, 1, 100);
        measure(2, 0, 100);        // echo rises late, at the count that would time out
        measure(0, 5, 100);        // echo stays high too long
        quiesce();

        // range boundaries: under min, exactly min, exactly max, over max
        configure(2, 1, 130, 2, 1, 3);
        measure(0, 57, 100);
        measure(0, 58, 100);
        measure(3, 116, 80);
        measure(0, 117, 100);
        measure(1, 115, 70);       // fraction truncated
        quiesce();

        // values outside the stated ranges: zero trigger, zero timeout
        configure(1, 1023, 0, 0, 3, 2);
        measure(0, 0, 100);
        measure(0, 2, 100);
        measure(1, 0, 100);

        // random runs in three idling modes, fresh small settings every few runs
        random_base = samples_sent;
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            mode_runs = 0;
            while ((samples_sent - random_base < (mode + 1) * RANDOM_ITEMS / 3)
                   || (mode_runs < RUNS_PER_MODE))
            begin
                if (mode_runs % 4 == 0)
                begin
                    quiesce();
                    mx  = $urandom_range(2, 3);
                    mn  = $urandom_range(0, mx);
                    tmo = $urandom_range(1, US_PER_CM * mx + 20);
                    trg = $urandom_range(1, 4);
                    if ($urandom_range(9) == 0)
                        tmo = 0;
                    if ($urandom_range(9) == 0)
                        trg = 0;
                    configure(mx, mn, tmo, trg, $urandom_range(0, 3), $urandom_range(0, 6));
                end
                // mostly well-formed echoes, some lost or stuck high
                kind  = $urandom_range(99);
                rise  = $urandom_range(0, 8);
                pulse = $urandom_range(0, US_PER_CM * cur_max + 30);
                if (kind < 12)
                    rise = cur_timeout + 1 + $urandom_range(0, 3);
                else if (kind < 24)
                    pulse = cur_timeout + $urandom_range(1, 5);
                repeat ($urandom_range(0, 2))
                    send_sample(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
                measure(rise, pulse, $urandom_range(50, 100));
                mode_runs++;
            end
        end

        // widest range, timeout and trigger settings, no idling: a short echo
        // under the largest minimum reports the largest failure value
        quiesce();
        configure(1023, 1023, 65535, 255, 0, 0);
        measure(0, 3, 100);

        s_axis_tvalid <= 1'b0;
        while (tracker.pending_readings.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY + 4) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
